### src/central_force_euler_step_unit_assert.svh
// assertion macros used by central_force_euler_step_unit.sv
`ifndef CENTRAL_FORCE_EULER_STEP_UNIT_ASSERT_SVH
`define CENTRAL_FORCE_EULER_STEP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CFES_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cfes assertion failed");
`define CFES_ASSERT_NORST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("cfes assertion failed");
`else
`define CFES_ASSERT(name, clk, rstn, prop)
`define CFES_ASSERT_NORST(name, clk, prop)
`endif

`endif

### src/cfes_pkg.sv
package cfes_pkg;

  localparam int TS_W      = 17;
  localparam int STR_W     = 25;
  localparam int CFG_W     = 25;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_FRAC  = 16;
  // strength times step length
  localparam int SDT_W     = TS_W + STR_W;

  localparam logic [TS_W-1:0]  TS_RST  = 17'd655;
  localparam logic [STR_W-1:0] STR_RST = 25'd65536;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH  = 1'b1;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

endpackage

### src/cfes_mul.sv
module cfes_mul #(
  parameter int AW = 42,
  parameter int BW = 32
) (
  input  logic           clk_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BW-1:0]  b_i,
  output logic [AW+BW-1:0] p_o
);

  logic [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

### src/cfes_div.sv
module cfes_div #(
  parameter int NW = 59,
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d, quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DW:0]   trial, diff;
  logic          ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    trial  = {rem_q, num_q[NW-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      num_d = {num_q[NW-2:0], 1'b0};
      quo_d = {quo_q[NW-2:0], ge};
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### src/cfes_sqrt.sv
module cfes_sqrt #(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [2*W-1:0] rad_i,
  output logic           done_o,
  output logic [W-1:0]   root_o
);

  localparam int CW = $clog2(W + 1);

  logic           busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [2*W-1:0] rad_q, rad_d;
  logic [W-1:0]   root_q, root_d;
  logic [W+1:0]   rem_q, rem_d;
  logic [W+3:0]   rem2, trial, diff;
  logic           ge;

  // two radicand bits per cycle, one root bit
  always_comb begin
    rem2   = {rem_q, rad_q[2*W-1:2*W-2]};
    trial  = (W+4)'({root_q, 2'b01});
    diff   = rem2 - trial;
    ge     = rem2 >= trial;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    root_d = root_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      rad_d  = rad_i;
      root_d = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[2*W-3:0], 2'b00};
      root_d = {root_q[W-2:0], ge};
      rem_d  = ge ? diff[W+1:0] : rem2[W+1:0];
      cnt_d  = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    root_q <= root_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### src/central_force_euler_step_unit.sv
// One body under an inverse-square pull toward the origin, state in signed fixed
// point. A load request's result is valid the cycle after it is accepted. A step
// request runs the bit-serial square root and, unless the radius is zero, four
// runs of the shared one-bit-per-cycle divider, with all products made on one
// registered multiplier.
// One request is in flight at a time; the result is held until taken.
`include "central_force_euler_step_unit_assert.svh"

module central_force_euler_step_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic signed [31:0]            load_pos_x_i,
  input  logic signed [31:0]            load_pos_y_i,
  input  logic signed [31:0]            load_vel_x_i,
  input  logic signed [31:0]            load_vel_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            pos_x_o,
  output logic signed [31:0]            pos_y_o,
  output logic signed [31:0]            vel_x_o,
  output logic signed [31:0]            vel_y_o,
  output logic                          zero_radius_o,
  output logic                          saturated_o,
  input  logic                          cfg_we_i,
  input  logic [cfes_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cfes_pkg::CFG_W-1:0]    cfg_data_i
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int AW  = cfes_pkg::SDT_W;
  localparam int MA  = (AW > W) ? AW : W;
  localparam int MB0 = (W > cfes_pkg::TS_W) ? W : cfes_pkg::TS_W;
  localparam int MB  = (MB0 > F + 1) ? MB0 : F + 1;
  localparam int PW  = MA + MB;
  localparam int AU  = AW + F + 1;
  localparam int NB  = AU + 2 * F - 2 * cfes_pkg::CFG_FRAC;
  localparam int DN  = (W + F > NB) ? W + F : NB;
  localparam int LW  = (W > 32) ? W : 32;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_SQX       = 5'd1;
  localparam logic [4:0] ST_SQY       = 5'd2;
  localparam logic [4:0] ST_SUM       = 5'd3;
  localparam logic [4:0] ST_SQGO      = 5'd4;
  localparam logic [4:0] ST_SQRT      = 5'd5;
  localparam logic [4:0] ST_R2        = 5'd6;
  localparam logic [4:0] ST_SDT       = 5'd7;
  localparam logic [4:0] ST_SDTC      = 5'd8;
  localparam logic [4:0] ST_DIVU_GO   = 5'd9;
  localparam logic [4:0] ST_DIVU_WAIT = 5'd10;
  localparam logic [4:0] ST_MULU      = 5'd11;
  localparam logic [4:0] ST_CAPA      = 5'd12;
  localparam logic [4:0] ST_DIVQ_WAIT = 5'd13;
  localparam logic [4:0] ST_PX        = 5'd14;
  localparam logic [4:0] ST_PY        = 5'd15;
  localparam logic [4:0] ST_PYC       = 5'd16;
  localparam logic [4:0] ST_OUT       = 5'd17;

  localparam logic signed [W+1:0] CMAX = {3'b000, {(W-1){1'b1}}};
  localparam logic signed [W+1:0] CMIN = ~CMAX;
  localparam logic signed [LW:0]  LMAX = {{(LW+2-W){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [LW:0]  LMIN = ~LMAX;

  logic [4:0] state_q, state_d;

  logic [cfes_pkg::TS_W-1:0]  ts_q;
  logic [cfes_pkg::STR_W-1:0] str_q;

  logic signed [W-1:0] px_q, px_d, py_q, py_d, vx_q, vx_d, vy_q, vy_d;
  logic                sat_q, sat_d, zr_q, zr_d, axis_q, axis_d;
  logic [W-1:0]        ax_q, ax_d, ay_q, ay_d, r_q, r_d;
  logic [2*W-1:0]      s_q, s_d, r2_q, r2_d;
  logic [AW-1:0]       sdt_q, sdt_d;
  logic [F:0]          u_q, u_d;

  logic [MA-1:0]       mul_a;
  logic [MB-1:0]       mul_b;
  logic [PW-1:0]       prod;

  logic                sq_start, sq_done;
  logic [W-1:0]        sq_root;
  logic                div_start, div_done;
  logic [DN-1:0]       div_num, div_quo;
  logic [2*W-1:0]      div_den;

  logic [W-1:0]        vxm, vym, cmag;
  logic [AU+2*F-1:0]   a_wide;
  logic [W:0]          dv;
  logic signed [W-1:0] vsel, csel;
  logic signed [W+1:0] vnew, pnew;
  logic [W-1:0]        dp;
  logic [W:0]          cl_v, cl_p;
  logic [W:0]          ld_px, ld_py, ld_vx, ld_vy;

  function automatic logic [W:0] clamp_w(input logic signed [W+1:0] v);
    logic [W:0] res;
    if (v > CMAX) begin
      res = {1'b1, CMAX[W-1:0]};
    end else if (v < CMIN) begin
      res = {1'b1, CMIN[W-1:0]};
    end else begin
      res = {1'b0, v[W-1:0]};
    end
    return res;
  endfunction

  function automatic logic [W:0] clamp_ld(input logic signed [31:0] d);
    logic signed [LW:0] e;
    logic [W:0]         res;
    e = (LW+1)'(d);
    if (e > LMAX) begin
      res = {1'b1, LMAX[W-1:0]};
    end else if (e < LMIN) begin
      res = {1'b1, LMIN[W-1:0]};
    end else begin
      res = {1'b0, e[W-1:0]};
    end
    return res;
  endfunction

  cfes_mul #(.AW(MA), .BW(MB)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  cfes_sqrt #(.W(W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (s_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  cfes_div #(.NW(DN), .DW(2*W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign vxm    = vx_q[W-1] ? W'(-vx_q) : W'(vx_q);
  assign vym    = vy_q[W-1] ? W'(-vy_q) : W'(vy_q);
  assign cmag   = axis_q ? ay_q : ax_q;
  assign vsel   = axis_q ? vy_q : vx_q;
  assign csel   = axis_q ? py_q : px_q;
  assign a_wide = {prod[AU-1:0], {(2*F){1'b0}}};

  // velocity change, capped at 2^W
  always_comb begin
    if ((|div_quo[DN-1:W+1]) || (div_quo[W] && (|div_quo[W-1:0]))) begin
      dv = {1'b1, {W{1'b0}}};
    end else begin
      dv = div_quo[W:0];
    end
    if (csel > 0) begin
      vnew = (W+2)'(vsel) - (W+2)'(dv);
    end else if (csel < 0) begin
      vnew = (W+2)'(vsel) + (W+2)'(dv);
    end else begin
      vnew = (W+2)'(vsel);
    end
    cl_v = clamp_w(vnew);
  end

  // position move for the axis whose product is in the multiplier output
  always_comb begin
    dp = prod[W+cfes_pkg::CFG_FRAC-1:cfes_pkg::CFG_FRAC];
    if (state_q == ST_PY) begin
      pnew = vx_q[W-1] ? (W+2)'(px_q) - (W+2)'(dp) : (W+2)'(px_q) + (W+2)'(dp);
    end else begin
      pnew = vy_q[W-1] ? (W+2)'(py_q) - (W+2)'(dp) : (W+2)'(py_q) + (W+2)'(dp);
    end
    cl_p = clamp_w(pnew);
  end

  assign ld_px = clamp_ld(load_pos_x_i);
  assign ld_py = clamp_ld(load_pos_y_i);
  assign ld_vx = clamp_ld(load_vel_x_i);
  assign ld_vy = clamp_ld(load_vel_y_i);

  always_comb begin
    state_d   = state_q;
    px_d      = px_q;
    py_d      = py_q;
    vx_d      = vx_q;
    vy_d      = vy_q;
    sat_d     = sat_q;
    zr_d      = zr_q;
    axis_d    = axis_q;
    ax_d      = ax_q;
    ay_d      = ay_q;
    r_d       = r_q;
    s_d       = s_q;
    r2_d      = r2_q;
    sdt_d     = sdt_q;
    u_d       = u_q;
    mul_a     = MA'(ax_q);
    mul_b     = MB'(ax_q);
    sq_start  = 1'b0;
    div_start = 1'b0;
    div_num   = DN'({cmag, {F{1'b0}}});
    div_den   = (2*W)'(r_q);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sat_d = 1'b0;
          zr_d  = 1'b0;
          if (action_i == cfes_pkg::ACT_LOAD) begin
            px_d    = ld_px[W-1:0];
            py_d    = ld_py[W-1:0];
            vx_d    = ld_vx[W-1:0];
            vy_d    = ld_vy[W-1:0];
            sat_d   = ld_px[W] | ld_py[W] | ld_vx[W] | ld_vy[W];
            state_d = ST_OUT;
          end else begin
            ax_d    = px_q[W-1] ? W'(-px_q) : W'(px_q);
            ay_d    = py_q[W-1] ? W'(-py_q) : W'(py_q);
            state_d = ST_SQX;
          end
        end
      end
      ST_SQX: begin
        mul_a   = MA'(ax_q);
        mul_b   = MB'(ax_q);
        state_d = ST_SQY;
      end
      ST_SQY: begin
        mul_a   = MA'(ay_q);
        mul_b   = MB'(ay_q);
        s_d     = prod[2*W-1:0];
        state_d = ST_SUM;
      end
      ST_SUM: begin
        s_d     = s_q + prod[2*W-1:0];
        state_d = ST_SQGO;
      end
      ST_SQGO: begin
        sq_start = 1'b1;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_done) begin
          r_d = sq_root;
          if (sq_root == '0) begin
            zr_d    = 1'b1;
            state_d = ST_PX;
          end else begin
            state_d = ST_R2;
          end
        end
      end
      ST_R2: begin
        mul_a   = MA'(r_q);
        mul_b   = MB'(r_q);
        state_d = ST_SDT;
      end
      ST_SDT: begin
        r2_d    = prod[2*W-1:0];
        mul_a   = MA'(str_q);
        mul_b   = MB'(ts_q);
        state_d = ST_SDTC;
      end
      ST_SDTC: begin
        sdt_d   = prod[AW-1:0];
        axis_d  = 1'b0;
        state_d = ST_DIVU_GO;
      end
      ST_DIVU_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIVU_WAIT;
      end
      ST_DIVU_WAIT: begin
        if (div_done) begin
          u_d     = div_quo[F:0];
          state_d = ST_MULU;
        end
      end
      ST_MULU: begin
        mul_a   = MA'(sdt_q);
        mul_b   = MB'(u_q);
        state_d = ST_CAPA;
      end
      ST_CAPA: begin
        div_start = 1'b1;
        div_num   = DN'(a_wide[AU+2*F-1:2*cfes_pkg::CFG_FRAC]);
        div_den   = r2_q;
        state_d   = ST_DIVQ_WAIT;
      end
      ST_DIVQ_WAIT: begin
        if (div_done) begin
          sat_d = sat_q | cl_v[W];
          if (axis_q) begin
            vy_d    = cl_v[W-1:0];
            state_d = ST_PX;
          end else begin
            vx_d    = cl_v[W-1:0];
            axis_d  = 1'b1;
            state_d = ST_DIVU_GO;
          end
        end
      end
      ST_PX: begin
        mul_a   = MA'(vxm);
        mul_b   = MB'(ts_q);
        state_d = ST_PY;
      end
      ST_PY: begin
        px_d    = cl_p[W-1:0];
        sat_d   = sat_q | cl_p[W];
        mul_a   = MA'(vym);
        mul_b   = MB'(ts_q);
        state_d = ST_PYC;
      end
      ST_PYC: begin
        py_d    = cl_p[W-1:0];
        sat_d   = sat_q | cl_p[W];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ts_q    <= cfes_pkg::TS_RST;
      str_q   <= cfes_pkg::STR_RST;
      px_q    <= '0;
      py_q    <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      sat_q   <= 1'b0;
      zr_q    <= 1'b0;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      px_q    <= px_d;
      py_q    <= py_d;
      vx_q    <= vx_d;
      vy_q    <= vy_d;
      sat_q   <= sat_d;
      zr_q    <= zr_d;
      axis_q  <= axis_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == cfes_pkg::REG_TIME_STEP) begin
          ts_q <= cfg_data_i[cfes_pkg::TS_W-1:0];
        end else if (cfg_idx_i == cfes_pkg::REG_STRENGTH) begin
          str_q <= cfg_data_i[cfes_pkg::STR_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q  <= ax_d;
    ay_q  <= ay_d;
    r_q   <= r_d;
    s_q   <= s_d;
    r2_q  <= r2_d;
    sdt_q <= sdt_d;
    u_q   <= u_d;
  end

  logic signed [LW-1:0] px_e, py_e, vx_e, vy_e;
  assign px_e = LW'(px_q);
  assign py_e = LW'(py_q);
  assign vx_e = LW'(vx_q);
  assign vy_e = LW'(vy_q);

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_OUT);
  assign pos_x_o       = px_e[31:0];
  assign pos_y_o       = py_e[31:0];
  assign vel_x_o       = vx_e[31:0];
  assign vel_y_o       = vy_e[31:0];
  assign zero_radius_o = zr_q;
  assign saturated_o   = sat_q;

  `CFES_ASSERT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `CFES_ASSERT(a_out_excl_in, clk_i, rst_ni, out_valid_o |-> !in_ready_o)
  `CFES_ASSERT(a_div_done_state, clk_i, rst_ni,
               div_done |-> (state_q == ST_DIVU_WAIT || state_q == ST_DIVQ_WAIT))
  `CFES_ASSERT(a_sqrt_done_state, clk_i, rst_ni, sq_done |-> state_q == ST_SQRT)

endmodule
